FILE: rtl/core/simt_rs_pkg.sv
// ---------------------------------------------------------------------------
// simt_rs_pkg
// shared constants for the warp reconvergence stack
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package simt_rs_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int WARP_LANES  = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] OP_PUSH       = 3'd0;
    localparam logic [2:0] OP_POP_AT     = 3'd1;
    localparam logic [2:0] OP_POP_BTW    = 3'd2;
    localparam logic [2:0] OP_LANE_MASK  = 3'd3;
    localparam logic [2:0] OP_CHK_BREAK  = 3'd4;
    localparam logic [2:0] OP_CHK_CONT   = 3'd5;
    localparam logic [2:0] OP_CHK_CALL   = 3'd6;

    localparam logic [2:0] KIND_BRANCH = 3'd1;
    localparam logic [2:0] KIND_CALL   = 3'd2;
    localparam logic [2:0] KIND_BREAK  = 3'd3;
    localparam logic [2:0] KIND_CONT   = 3'd4;

    localparam logic [1:0] MK_BREAK = 2'd0;
    localparam logic [1:0] MK_CONT  = 2'd1;
    localparam logic [1:0] MK_EXIT  = 2'd2;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_FULL     = 3'd1;
    localparam logic [2:0] ERR_DUP      = 3'd2;
    localparam logic [2:0] ERR_MASK     = 3'd3;
    localparam logic [2:0] ERR_NO_BREAK = 3'd4;
    localparam logic [2:0] ERR_CONT     = 3'd5;
endpackage

FILE: rtl/core/simt_reconvergence_stack.sv
// ---------------------------------------------------------------------------
// simt_reconvergence_stack
// warp divergence stack walked one entry per cycle by a small sequencer
// ---------------------------------------------------------------------------
// channel  | handshake      | fields
// command  | start / busy   | op pc bound_pc mask_in kind lane mask_kind
// result   | done           | found mask_out addr_out error
//
// after a command the sequencer passes through a read state, a walk state that
// visits each live entry, a finish state, and then raises the result strobe;
// on an empty stack the read and walk states are skipped
// busy stays high through the strobe cycle, so the next command is taken after it
// reset clears the sequencer and the entry count; entries beyond it are never used
// results cannot be stalled: done is a one-cycle strobe
`timescale 1ns / 1ps
module simt_reconvergence_stack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [31:0] pc,
    input  logic [31:0] bound_pc,
    input  logic [31:0] mask_in,
    input  logic [2:0]  kind,
    input  logic [4:0]  lane,
    input  logic [1:0]  mask_kind,
    output logic        done,
    output logic        found,
    output logic [31:0] mask_out,
    output logic [31:0] addr_out,
    output logic [2:0]  error
);
    import simt_rs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [31:0] mem_pc   [STACK_DEPTH];
    logic [31:0] mem_mask [STACK_DEPTH];
    logic [2:0]  mem_kind [STACK_DEPTH];

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;   // entries still to visit
    logic [CNT_W-1:0] wr_reg, wr_next;     // compaction write pointer
    logic [2:0]  op_reg;
    logic [31:0] a_reg, b_reg, min_reg;
    logic [2:0]  kind_reg;
    logic [31:0] bit_reg;
    logic [31:0] pmask_reg;
    logic [1:0]  mk_reg;
    logic        stop_reg, stop_next;
    logic        f1_reg, f1_next, f2_reg, f2_next, bad_reg, bad_next;
    logic [4:0]  dup_reg, dup_next;
    logic [31:0] acc_reg, acc_next, brk_reg, brk_next, cnt_reg, cnt_next;
    logic [31:0] ad_reg, ad_next;
    logic [31:0] rpc_reg, rmask_reg;
    logic [2:0]  rkind_reg;
    logic [IDX_W-1:0] ridx_reg, rd_idx;
    logic        we;
    logic [IDX_W-1:0] w_idx;
    logic [31:0] w_pc, w_mask;
    logic [2:0]  w_kind;
    logic        o_found;
    logic [31:0] o_mask, o_addr;
    logic [2:0]  o_err;
    logic        sel, bottom_up;

    assign busy = (state_reg != ST_IDLE) | done;
    // compaction, call search and the push duplicate scan go bottom up, the rest top down
    assign bottom_up = (op_reg == OP_POP_AT) || (op_reg == OP_POP_BTW)
        || (op_reg == OP_CHK_CALL) || (op_reg == OP_PUSH);
    assign sel = (op_reg == OP_POP_AT) ? (rpc_reg == a_reg)
        : ((rpc_reg > min_reg) && (rpc_reg < b_reg));

    always_comb
    begin
        if (state_reg == ST_IDLE)
            rd_idx = '0;
        else if (bottom_up)
            rd_idx = IDX_W'(count_reg - pos_reg);
        else
            rd_idx = IDX_W'(pos_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_pc[w_idx]   <= w_pc;
            mem_mask[w_idx] <= w_mask;
            mem_kind[w_idx] <= w_kind;
        end
        rpc_reg   <= mem_pc[rd_idx];
        rmask_reg <= mem_mask[rd_idx];
        rkind_reg <= mem_kind[rd_idx];
        ridx_reg  <= rd_idx;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= op;
            a_reg     <= pc;
            b_reg     <= (pc < bound_pc) ? bound_pc : pc;
            min_reg   <= (pc < bound_pc) ? pc : bound_pc;
            kind_reg  <= kind;
            bit_reg   <= (32'(lane) < 32'(WARP_LANES)) ? (32'd1 << lane) : 32'd0;
            mk_reg    <= mask_kind;
            pmask_reg <= mask_in;
        end
        if (state_next == ST_FIN || state_reg == ST_FIN)
        begin
            found    <= o_found;
            mask_out <= o_mask;
            addr_out <= o_addr;
            error    <= o_err;
        end
        f1_reg  <= f1_next;
        f2_reg  <= f2_next;
        bad_reg <= bad_next;
        dup_reg <= dup_next;
        acc_reg <= acc_next;
        brk_reg <= brk_next;
        cnt_reg <= cnt_next;
        ad_reg  <= ad_next;
        stop_reg <= stop_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        wr_next = wr_reg;
        stop_next = stop_reg;
        f1_next = f1_reg; f2_next = f2_reg; bad_next = bad_reg;
        dup_next = dup_reg;
        acc_next = acc_reg; brk_next = brk_reg; cnt_next = cnt_reg;
        ad_next = ad_reg;
        we = 1'b0; w_idx = ridx_reg; w_pc = rpc_reg; w_mask = rmask_reg;
        w_kind = rkind_reg;
        o_found = 1'b0; o_mask = '0; o_addr = '0; o_err = ERR_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && !busy)
                begin
                    pos_next = count_reg;
                    wr_next = '0;
                    stop_next = 1'b0;
                    f1_next = 1'b0; f2_next = 1'b0; bad_next = 1'b0;
                    dup_next = (kind == KIND_BRANCH || kind == KIND_CALL) ? 5'd0 : 5'd1;
                    acc_next = '0; brk_next = '0; cnt_next = '0; ad_next = '0;
                    state_next = (count_reg == '0) ? ST_FIN : ST_RD;
                end
            end
            ST_RD:
            begin
                // memory read of first entry in flight
                pos_next = pos_reg - 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (!stop_reg)
                begin
                    case (op_reg)
                        OP_PUSH:
                        begin
                            if (rpc_reg == a_reg && rkind_reg != KIND_BRANCH
                                && rkind_reg != KIND_CALL && dup_reg != 5'd2)
                                dup_next = dup_reg + 5'd1;
                        end
                        OP_POP_AT, OP_POP_BTW:
                        begin
                            if (sel)
                            begin
                                acc_next = acc_reg | rmask_reg;
                                f1_next = 1'b1;
                            end
                            else
                            begin
                                we = 1'b1;
                                w_idx = IDX_W'(wr_reg);
                                wr_next = wr_reg + 1'b1;
                            end
                        end
                        OP_LANE_MASK:
                        begin
                            if (mk_reg == MK_BREAK && rkind_reg == KIND_BREAK)
                            begin
                                f1_next = 1'b1; stop_next = 1'b1;
                            end
                            else if (mk_reg == MK_CONT && rkind_reg == KIND_CONT)
                            begin
                                we = 1'b1; w_mask = rmask_reg | bit_reg;
                                f1_next = 1'b1; stop_next = 1'b1;
                            end
                            else
                            begin
                                we = 1'b1; w_mask = rmask_reg & ~bit_reg;
                            end
                        end
                        OP_CHK_BREAK:
                        begin
                            if (rkind_reg == KIND_BREAK)
                            begin
                                f1_next = 1'b1; stop_next = 1'b1;
                                f2_next = (rmask_reg & acc_reg) == '0;
                                ad_next = rpc_reg;
                            end
                            else
                                acc_next = acc_reg | rmask_reg;
                        end
                        OP_CHK_CONT:
                        begin
                            if (rkind_reg == KIND_CONT)
                            begin
                                if (f1_reg)
                                begin
                                    bad_next = 1'b1; stop_next = 1'b1;
                                end
                                else
                                begin
                                    f1_next = 1'b1; cnt_next = rmask_reg;
                                    ad_next = rpc_reg;
                                    acc_next = acc_reg | rmask_reg;
                                end
                            end
                            else if (rkind_reg == KIND_BREAK)
                            begin
                                brk_next = rmask_reg; f2_next = 1'b1;
                                stop_next = 1'b1;
                            end
                            else
                                acc_next = acc_reg | rmask_reg;
                        end
                        OP_CHK_CALL:
                        begin
                            if (rkind_reg == KIND_CALL)
                            begin
                                f1_next = 1'b1; stop_next = 1'b1;
                                acc_next = rmask_reg; ad_next = rpc_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                if (pos_reg == '0)
                    state_next = ST_FIN;
                else
                    pos_next = pos_reg - 1'b1;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (count_reg >= CNT_W'(STACK_DEPTH))
                            o_err = ERR_FULL;
                        else if (dup_reg >= 5'd2)
                            o_err = ERR_DUP;
                        else
                        begin
                            we = 1'b1; w_idx = IDX_W'(count_reg);
                            w_pc = a_reg; w_mask = pmask_reg; w_kind = kind_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_POP_AT, OP_POP_BTW:
                    begin
                        o_found = f1_reg;
                        o_mask = (op_reg == OP_POP_AT) ? acc_reg : '0;
                        count_next = wr_reg;
                    end
                    OP_LANE_MASK:
                        o_err = (!f1_reg && mk_reg != MK_EXIT) ? ERR_MASK : ERR_OK;
                    OP_CHK_BREAK:
                    begin
                        o_found = f2_reg; o_addr = ad_reg;
                        o_err = f1_reg ? ERR_OK : ERR_NO_BREAK;
                    end
                    OP_CHK_CONT:
                    begin
                        if (bad_reg || !f1_reg || !f2_reg)
                            o_err = ERR_CONT;
                        else
                        begin
                            o_found = (((~acc_reg & brk_reg) ^ cnt_reg) == brk_reg);
                            o_addr = ad_reg;
                        end
                    end
                    OP_CHK_CALL:
                    begin
                        o_found = f1_reg; o_mask = acc_reg; o_addr = ad_reg;
                    end
                    default: ;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            wr_reg    <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            wr_reg    <= wr_next;
            done      <= (state_reg == ST_FIN);
        end
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH)) else $error("count overflow");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("double strobe");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> done) else $error("missing strobe");
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !(start && !busy)) |=> $stable(count_reg))
        else $error("count moved while idle");
endmodule
